/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the plateau selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked while reset is released.
`define CPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CPS_ASSERT(lbl, clk, rstn, prop, msg)
`define CPS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* src/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg
// Sizes, widths and controller/datapath signal groups of the plateau selector.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int VAL_W     = 32;

    // Item counter must hold MAX_ITEMS itself; an index needs one value less.
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // Disjoint plateaus of length one are the densest packing: at most half the list.
    localparam int TIE_DEPTH = MAX_ITEMS / 2;
    localparam int TIE_AW    = (TIE_DEPTH > 1) ? $clog2(TIE_DEPTH) : 1;
    localparam int TCNT_W    = $clog2(TIE_DEPTH + 1);

    typedef struct packed {
        logic load;     // an input beat is accepted
        logic close;    // close the open run after the final beat
        logic pos;      // form the read position from the tie store output
        logic capture;  // move the read value into the output register
    } t_cmd;

    typedef struct packed {
        logic out_free; // output register can take a new result
    } t_status;

endpackage

/* src/cps_if.sv */
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface cps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cps_pkg::VAL_W-1:0]     value;
    logic                                 last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface cps_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cps_pkg::VAL_W-1:0]     central_value;
    logic                                 overflow;

    modport source (output valid, output central_value, output overflow, input ready);
    modport sink   (input valid, input central_value, input overflow, output ready);
endinterface

/* src/cps_ctrl.sv */
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer: loads beats, then steps through close, tie read, position, value read
// and result capture.
// ----------------------------------------------------------------------------
module cps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  cps_pkg::t_status  i_status,
    output cps_pkg::t_cmd     o_cmd
);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_CLOSE = 6'b000010,
        S_SEL   = 6'b000100,
        S_TIE   = 6'b001000,
        S_RDV   = 6'b010000,
        S_CAP   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_load;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_load     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_load;
        o_cmd.close   = (r_state == S_CLOSE);
        o_cmd.pos     = (r_state == S_TIE);
        o_cmd.capture = (r_state == S_CAP) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_load && i_in_last) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: n_state = S_SEL;
            S_SEL:   n_state = S_TIE;
            S_TIE:   n_state = S_RDV;
            S_RDV:   n_state = S_CAP;
            S_CAP: begin
                if (i_status.out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/cps_datapath.sv */
// ----------------------------------------------------------------------------
// cps_datapath
// Run tracking, value and tie-start stores, position arithmetic and the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cps_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cps_pkg::t_cmd                       i_cmd,
    output cps_pkg::t_status                    o_status,
    input  logic signed [cps_pkg::VAL_W-1:0]    i_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [cps_pkg::VAL_W-1:0]    o_central_value,
    output logic                                o_overflow
);

    localparam logic [cps_pkg::VAL_W-1:0] TOP_VALUE = {1'b0, {(cps_pkg::VAL_W-1){1'b1}}};

    logic [cps_pkg::VAL_W-1:0]  val_mem [cps_pkg::MAX_ITEMS];
    logic [cps_pkg::IDX_W-1:0]  tie_mem [cps_pkg::TIE_DEPTH];

    logic [cps_pkg::CNT_W-1:0]  r_item_count,  n_item_count;
    logic [cps_pkg::VAL_W-1:0]  r_prev,        n_prev;
    logic                       r_in_run,      n_in_run;
    logic [cps_pkg::IDX_W-1:0]  r_run_start,   n_run_start;
    logic [cps_pkg::CNT_W-1:0]  r_run_length,  n_run_length;
    logic [cps_pkg::TCNT_W-1:0] r_plateau_cnt, n_plateau_cnt;
    logic [cps_pkg::CNT_W-1:0]  r_longest,     n_longest;
    logic [cps_pkg::TCNT_W-1:0] r_tie_count,   n_tie_count;
    logic                       r_overflow,    n_overflow;

    logic [cps_pkg::IDX_W-1:0]  r_tie_q;
    logic [cps_pkg::VAL_W-1:0]  r_val_q;
    logic [cps_pkg::IDX_W-1:0]  r_pos;
    logic                       r_out_valid;
    logic [cps_pkg::VAL_W-1:0]  r_central;
    logic                       r_out_ovf;

    logic [cps_pkg::VAL_W-1:0]  w_value;
    logic                       w_store, w_flag, w_has_prev, w_extend, w_close;
    logic                       w_tie_we;
    logic [cps_pkg::TIE_AW-1:0] w_tie_waddr;
    logic [cps_pkg::TCNT_W-1:0] w_half, w_sel;
    logic [cps_pkg::CNT_W-1:0]  w_pos_raw, w_pos;

    assign w_value    = $unsigned(i_value);
    assign w_store    = i_cmd.load && (r_item_count < cps_pkg::CNT_W'(cps_pkg::MAX_ITEMS));
    assign w_has_prev = (r_item_count != '0);
    // The largest positive value has no successor, so a run can neither start at it nor continue past it.
    assign w_flag     = (r_prev != TOP_VALUE) && ((r_prev + 1'b1) == w_value);
    assign w_extend   = w_store && w_has_prev && w_flag;
    assign w_close    = r_in_run && (i_cmd.close || (w_store && w_has_prev && !w_flag));

    always_comb begin
        n_item_count  = r_item_count;
        n_prev        = r_prev;
        n_in_run      = r_in_run;
        n_run_start   = r_run_start;
        n_run_length  = r_run_length;
        n_plateau_cnt = r_plateau_cnt;
        n_longest     = r_longest;
        n_tie_count   = r_tie_count;
        n_overflow    = r_overflow;
        w_tie_we      = 1'b0;
        w_tie_waddr   = '0;

        if (i_cmd.capture) begin
            n_item_count  = '0;
            n_prev        = '0;
            n_in_run      = 1'b0;
            n_run_start   = '0;
            n_run_length  = '0;
            n_plateau_cnt = '0;
            n_longest     = '0;
            n_tie_count   = '0;
            n_overflow    = 1'b0;
        end else begin
            if (i_cmd.load && !w_store) begin
                n_overflow = 1'b1;
            end
            if (w_store) begin
                n_prev       = w_value;
                n_item_count = r_item_count + 1'b1;
            end
            if (w_extend) begin
                if (!r_in_run) begin
                    n_in_run     = 1'b1;
                    n_run_start  = cps_pkg::IDX_W'(r_item_count - 1'b1);
                    n_run_length = cps_pkg::CNT_W'(1);
                end else begin
                    n_run_length = r_run_length + 1'b1;
                end
            end
            if (w_close) begin
                n_plateau_cnt = r_plateau_cnt + 1'b1;
                n_in_run      = 1'b0;
                n_run_length  = '0;
                if (r_run_length > r_longest) begin
                    n_longest   = r_run_length;
                    w_tie_we    = 1'b1;
                    w_tie_waddr = '0;
                    n_tie_count = cps_pkg::TCNT_W'(1);
                end else if ((r_run_length == r_longest) &&
                             (r_tie_count < cps_pkg::TCNT_W'(cps_pkg::TIE_DEPTH))) begin
                    w_tie_we    = 1'b1;
                    w_tie_waddr = cps_pkg::TIE_AW'(r_tie_count);
                    n_tie_count = r_tie_count + 1'b1;
                end
            end
        end
    end

    // Tie pick: (k+1)/2 rounded half to even, then made zero-based.
    always_comb begin
        if (r_tie_count[0]) begin
            w_half = (r_tie_count >> 1) + 1'b1;
        end else begin
            w_half = r_tie_count >> 1;
            if (w_half[0]) begin
                w_half = w_half + 1'b1;
            end
        end
        w_sel = w_half - 1'b1;
        if (w_sel >= r_tie_count) begin
            w_sel = r_tie_count - 1'b1;
        end
    end

    always_comb begin
        if ((r_plateau_cnt > cps_pkg::TCNT_W'(1)) && (r_tie_count != '0)) begin
            w_pos_raw = cps_pkg::CNT_W'(r_tie_q) + (r_longest >> 1);
        end else begin
            w_pos_raw = (r_item_count - 1'b1) >> 1;
        end
        w_pos = w_pos_raw;
        if (w_pos_raw >= r_item_count) begin
            w_pos = r_item_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            val_mem[r_item_count[cps_pkg::IDX_W-1:0]] <= w_value;
        end
        r_val_q <= val_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (w_tie_we) begin
            tie_mem[w_tie_waddr] <= r_run_start;
        end
        r_tie_q <= tie_mem[w_sel[cps_pkg::TIE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos) begin
            r_pos <= w_pos[cps_pkg::IDX_W-1:0];
        end
        if (i_cmd.capture) begin
            r_central <= r_val_q;
            r_out_ovf <= r_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count  <= '0;
            r_prev        <= '0;
            r_in_run      <= 1'b0;
            r_run_start   <= '0;
            r_run_length  <= '0;
            r_plateau_cnt <= '0;
            r_longest     <= '0;
            r_tie_count   <= '0;
            r_overflow    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_item_count  <= n_item_count;
            r_prev        <= n_prev;
            r_in_run      <= n_in_run;
            r_run_start   <= n_run_start;
            r_run_length  <= n_run_length;
            r_plateau_cnt <= n_plateau_cnt;
            r_longest     <= n_longest;
            r_tie_count   <= n_tie_count;
            r_overflow    <= n_overflow;
            if (i_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_central_value   = $signed(r_central);
    assign o_overflow        = r_out_ovf;

    `CPS_ASSERT(a_clear_after_capture, i_clk, i_rst_n, i_cmd.capture |=> (r_item_count == '0 && r_tie_count == '0 && !r_in_run), "list state not cleared after result capture")
    `CPS_ASSERT(a_run_len_matches, i_clk, i_rst_n, r_in_run == (r_run_length != '0), "open-run flag and run length disagree")
    `CPS_ASSERT(a_tie_bound, i_clk, i_rst_n, r_tie_count <= cps_pkg::TCNT_W'(cps_pkg::TIE_DEPTH), "tie count exceeds tie store depth")
    `CPS_ASSERT(a_close_ends_run, i_clk, i_rst_n, i_cmd.close |=> !r_in_run, "run still open after the closing step")

endmodule

/* src/central_plateau_selector.sv */
// ----------------------------------------------------------------------------
// central_plateau_selector
// Picks the central value of a list; when the list holds more than one plateau
// of consecutive integers, it takes the middle of the middle longest plateau.
// ----------------------------------------------------------------------------
// Loading takes one beat per cycle; the stores have one write port each.
// After the final beat the input stalls through the close run, tie store read,
// position, value store read and capture steps; capture waits for the output
// register to be free, and the next list may load while the result waits.
// Synchronous active-low reset clears counters and run state at once; the
// stores need no clearing pass since only written entries are ever read.
module central_plateau_selector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cps_in_if.sink        i_in,
    cps_out_if.source     o_out
);

    cps_pkg::t_cmd    w_cmd;
    cps_pkg::t_status w_status;

    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cps_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_value         (i_in.value),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_central_value (o_out.central_value),
        .o_overflow      (o_out.overflow)
    );

endmodule

/* verif/central_plateau_selector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// central_plateau_selector_tb
// Streams lists of signed positions into the selector and checks each central
// value and overflow flag against a behavioral predictor. A short table of
// hand-picked lists opens the run. Random lists follow, built from runs of
// consecutive integers, noise and values near the ends of the range. They are
// sent under changing idle and stall patterns, including one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module central_plateau_selector_tb;

    localparam logic [cps_pkg::VAL_W-1:0] TOP_VAL    = 32'h7FFF_FFFF;
    localparam logic [cps_pkg::VAL_W-1:0] BOTTOM_VAL = 32'h8000_0000;
    localparam int               TARGET_BEATS = 900;
    localparam int               QUIET_LIMIT  = 4000;
    localparam int               NUM_ROWS     = 23;

    typedef struct packed {
        logic signed [cps_pkg::VAL_W-1:0] central_value;
        logic                             overflow;
    } t_pick;

    typedef struct packed {
        logic [cps_pkg::VAL_W-1:0] value;
        logic                      last;
        logic                      typed;      // expected value given in the row
        logic [cps_pkg::VAL_W-1:0] exp_value;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    cps_in_if  in_bus ();
    cps_out_if out_bus ();

    central_plateau_selector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Hand-picked lists: single elements, the top of the range, one plateau,
    // two tied plateaus and one unique longest plateau among three.
    t_stim_row directed_rows [NUM_ROWS] = '{
        '{32'd5,      1'b1, 1'b1, 32'd5},
        '{BOTTOM_VAL, 1'b1, 1'b1, BOTTOM_VAL},
        '{TOP_VAL,    1'b1, 1'b1, TOP_VAL},
        '{TOP_VAL,    1'b0, 1'b0, 32'd0},
        '{BOTTOM_VAL, 1'b0, 1'b0, 32'd0},
        '{32'd0,      1'b1, 1'b1, BOTTOM_VAL},
        '{32'd1,      1'b0, 1'b0, 32'd0},
        '{32'd2,      1'b0, 1'b0, 32'd0},
        '{32'd3,      1'b0, 1'b0, 32'd0},
        '{32'd10,     1'b1, 1'b1, 32'd2},
        '{32'd10,     1'b0, 1'b0, 32'd0},
        '{32'd11,     1'b0, 1'b0, 32'd0},
        '{32'd20,     1'b0, 1'b0, 32'd0},
        '{32'd21,     1'b0, 1'b0, 32'd0},
        '{32'd30,     1'b1, 1'b0, 32'd0},
        '{-32'sd3,    1'b0, 1'b0, 32'd0},
        '{-32'sd2,    1'b0, 1'b0, 32'd0},
        '{32'd7,      1'b0, 1'b0, 32'd0},
        '{32'd8,      1'b0, 1'b0, 32'd0},
        '{32'd9,      1'b0, 1'b0, 32'd0},
        '{-32'sd1,    1'b0, 1'b0, 32'd0},
        '{32'd0,      1'b0, 1'b0, 32'd0},
        '{32'd100,    1'b1, 1'b0, 32'd0}
    };

    // Predictor state for the list being loaded.
    logic [cps_pkg::VAL_W-1:0] seen_vals [cps_pkg::MAX_ITEMS];
    int unsigned      longest_starts [cps_pkg::TIE_DEPTH + 1];
    int unsigned      n_loaded = 0;
    logic [cps_pkg::VAL_W-1:0] prev_val = '0;
    bit               run_open = 1'b0;
    int unsigned      run_from = 0;
    int unsigned      run_len = 0;
    int unsigned      plateau_total = 0;
    int unsigned      best_len = 0;
    int unsigned      tie_total = 0;
    bit               ovf_seen = 1'b0;

    t_pick expected_picks [$];
    int    fail_count = 0;
    int    beats_sent = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    hold_cycles = 0;
    int    quiet_cycles = 0;

    function automatic void close_plateau();
        if (!run_open) return;
        plateau_total++;
        if (run_len > best_len) begin
            best_len          = run_len;
            longest_starts[0] = run_from;
            tie_total         = 1;
        end else if (run_len == best_len && tie_total < cps_pkg::TIE_DEPTH + 1) begin
            longest_starts[tie_total] = run_from;
            tie_total++;
        end
        run_open = 1'b0;
        run_len  = 0;
    endfunction

    // Returns 1 and the expected result when the beat closes a list.
    function automatic bit predict_pick(input logic [cps_pkg::VAL_W-1:0] v, input bit lst,
                                        output t_pick res);
        int unsigned k;
        int unsigned sel;
        int unsigned pos;
        res = '0;
        if (n_loaded >= cps_pkg::MAX_ITEMS) begin
            ovf_seen = 1'b1;
        end else begin
            if (n_loaded > 0) begin
                // The top of the range has no successor; no wrap is allowed.
                if (prev_val != TOP_VAL && prev_val + 32'd1 == v) begin
                    if (!run_open) begin
                        run_open = 1'b1;
                        run_from = n_loaded - 1;
                        run_len  = 0;
                    end
                    run_len++;
                end else begin
                    close_plateau();
                end
            end
            seen_vals[n_loaded] = v;
            prev_val            = v;
            n_loaded++;
        end
        if (!lst) return 1'b0;
        close_plateau();
        if (plateau_total > 1 && tie_total > 0) begin
            k = tie_total;
            // Round half to even of (k+1)/2, then count from zero.
            if (k & 1) begin
                sel = (k + 1) / 2;
            end else begin
                sel = k / 2;
                if (sel & 1) sel++;
            end
            sel = sel - 1;
            if (sel >= tie_total) sel = tie_total - 1;
            pos = longest_starts[sel] + best_len / 2;
        end else begin
            pos = (n_loaded - 1) / 2;
        end
        if (pos >= n_loaded) pos = n_loaded - 1;
        res.central_value = seen_vals[pos % cps_pkg::MAX_ITEMS];
        res.overflow      = ovf_seen;
        n_loaded      = 0;
        prev_val      = '0;
        run_open      = 1'b0;
        run_from      = 0;
        run_len       = 0;
        plateau_total = 0;
        best_len      = 0;
        tie_total     = 0;
        ovf_seen      = 1'b0;
        return 1'b1;
    endfunction

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    task automatic send_beat(input logic [cps_pkg::VAL_W-1:0] v, input bit lst,
                             input bit typed, input logic [cps_pkg::VAL_W-1:0] typed_value);
        t_pick res;
        bit    got;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.value <= v;
        in_bus.last  <= lst;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        beats_sent++;
        got = predict_pick(v, lst, res);
        if (got) begin
            if (typed) res.central_value = typed_value;
            expected_picks.insert(expected_picks.size(), res);
        end
    endtask

    // Lowers valid in the step of the last accepted beat, then waits.
    task automatic wait_for_results();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_picks.size() != 0) @(posedge i_clk);
    endtask

    // Builds a list from segments of consecutive values. A nonzero run_size
    // makes all segments equally long, which produces many tied plateaus.
    task automatic send_list(input int n, input int run_size);
        logic [cps_pkg::VAL_W-1:0] vals [$];
        logic [cps_pkg::VAL_W-1:0] base;
        int               seg;
        int               style;
        int               j;
        style = $urandom_range(0, 9);
        if (run_size == 0 && style < 4) run_size = $urandom_range(1, 4);
        while (vals.size() < n) begin
            case ($urandom_range(0, 7))
                0: begin
                    base = TOP_VAL - $urandom_range(0, 3);
                end
                1: begin
                    base = BOTTOM_VAL + $urandom_range(0, 3);
                end
                default: begin
                    base = $urandom;
                end
            endcase
            if (run_size != 0) begin
                seg = run_size;
            end else if (style < 8) begin
                seg = $urandom_range(0, 5);
            end else begin
                seg = 0;
            end
            for (j = 0; j <= seg && vals.size() < n; j++) vals.insert(vals.size(), base + j);
        end
        foreach (vals[i]) send_beat(vals[i], i == n - 1, 1'b0, '0);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        out_bus.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                out_bus.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_pick exp_pick;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_picks.size() == 0) begin
                $error("unexpected result beat: central_value %0d overflow %0b",
                       out_bus.central_value, out_bus.overflow);
                fail_count++;
            end else begin
                exp_pick = expected_picks.pop_front();
                if (out_bus.central_value !== exp_pick.central_value) begin
                    $error("central_value: expected %0d, got %0d",
                           exp_pick.central_value, out_bus.central_value);
                    fail_count++;
                end
                if (out_bus.overflow !== exp_pick.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           exp_pick.overflow, out_bus.overflow);
                    fail_count++;
                end
            end
        end
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int li;
        int n;
        int run_size;
        i_rst_n      = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.value = '0;
        in_bus.last  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_beat(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].exp_value);
        end
        wait_for_results();

        li = 0;
        while (beats_sent < TARGET_BEATS) begin
            if (li % 6 == 0) begin
                case ((li / 6) % 4)
                    0: begin
                        send_idle_pct = 0;
                        stall_pct     = 0;
                    end
                    1: begin
                        send_idle_pct = 78;
                        stall_pct     = 0;
                    end
                    2: begin
                        send_idle_pct = 0;
                        stall_pct     = 78;
                    end
                    default: begin
                        send_idle_pct = 10;
                        stall_pct     = 10;
                    end
                endcase
            end
            // Long receiver hold-off while two more short lists are sent.
            if (li == 14) hold_cycles = 400;
            run_size = 0;
            n        = $urandom_range(1, 24);
            if (li == 2) begin
                // Full store of length-one plateaus: the largest tie count.
                n        = cps_pkg::MAX_ITEMS;
                run_size = 1;
            end
            if (li == 9) n = cps_pkg::MAX_ITEMS + $urandom_range(1, 20);
            send_list(n, run_size);
            if (li % 8 == 7) wait_for_results();
            li++;
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_picks.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/cps_pkg.sv
src/cps_if.sv
src/cps_ctrl.sv
src/cps_datapath.sv
src/central_plateau_selector.sv
verif/central_plateau_selector_tb.sv
